### src/fat_partition_window_checker_top_macros.svh
// ----------------------------------------------------------------------------
// fat partition window checker assertion macros
// concurrent assertion wrappers used by the checker file fpwc_checker
// ----------------------------------------------------------------------------
`ifndef FAT_PARTITION_WINDOW_CHECKER_TOP_MACROS_SVH
`define FAT_PARTITION_WINDOW_CHECKER_TOP_MACROS_SVH

// same-cycle implication, skipped while in reset
`define FPWC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while in reset
`define FPWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fpwc_pkg.sv
// ----------------------------------------------------------------------------
// fpwc_pkg
// shared constants, codes and types of the fat partition window checker
// ----------------------------------------------------------------------------
`default_nettype none

package fpwc_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned POS_W        = $clog2(SECTOR_BYTES);
  localparam int unsigned IN_DATA_W    = 72;
  localparam int unsigned OUT_DATA_W   = 104;

  // command and reply kinds
  localparam logic CMD_SECTOR_BYTE = 1'b0;
  localparam logic CMD_ACCESS      = 1'b1;
  localparam logic REPLY_DETECT    = 1'b0;
  localparam logic REPLY_ACCESS    = 1'b1;

  // configuration register indexes
  localparam logic CFG_CARD_BLOCKS = 1'b0;
  localparam logic CFG_FORMAT_MODE = 1'b1;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  // sector 0 constants
  localparam logic [7:0] SIG_LOW     = 8'h55;
  localparam logic [7:0] SIG_HIGH    = 8'hAA;
  localparam logic [7:0] OP_JMP_SHORT = 8'hEB;
  localparam logic [7:0] OP_NOP       = 8'h90;
  localparam logic [7:0] OP_JMP_NEAR  = 8'hE9;
  localparam int unsigned ENTRY0_OFFSET = 446;
  localparam int unsigned ENTRY0_TYPE   = ENTRY0_OFFSET + 4;
  localparam int unsigned ENTRY0_LBA    = ENTRY0_OFFSET + 8;
  localparam logic [31:0] LBA_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    LAYOUT_NONE  = 2'd0,
    LAYOUT_WHOLE = 2'd1,
    LAYOUT_MBR   = 2'd2
  } layout_t;

  typedef struct packed {
    layout_t     layout;
    logic [31:0] start;
    logic [31:0] size;
  } det_result_t;

  function automatic logic fat_type(input logic [7:0] t);
    return (t == 8'h01) || (t == 8'h04) || (t == 8'h06) ||
           (t == 8'h0B) || (t == 8'h0C) || (t == 8'h0E);
  endfunction

endpackage

`default_nettype wire

### src/fpwc_detect.sv
// ----------------------------------------------------------------------------
// fpwc_detect
// captures the fields of sector 0 and decides the partition window
// ----------------------------------------------------------------------------
`default_nettype none

module fpwc_detect (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic [7:0]           byte_value,
  input  wire logic                 last_byte,
  input  wire logic [31:0]          card_blocks,
  input  wire logic                 format_mode,
  output fpwc_pkg::det_result_t     result
);

  logic [fpwc_pkg::POS_W-1:0] byte_position;
  // boot bytes 0..23 at 0..23, bytes 32..39 at 24..31
  logic [7:0] boot [32];
  logic [7:0] entry_lba [8];
  logic [7:0] entry_type;
  logic [7:0] sig_low;

  logic        full_sector;
  logic [15:0] bytes_per_sector, reserved, fat16_size, total16;
  logic [31:0] fat32_size, total32, first, size, room;
  logic [7:0]  spc, nf;
  logic        boot_ok, bpb_ok, mbr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (en) begin
      if (last_byte || byte_position == fpwc_pkg::POS_W'(fpwc_pkg::SECTOR_BYTES - 1)) begin
        byte_position <= '0;
      end else begin
        byte_position <= byte_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (byte_position < fpwc_pkg::POS_W'(24)) begin
        boot[byte_position[4:0]] <= byte_value;
      end
      if (byte_position >= fpwc_pkg::POS_W'(32) && byte_position < fpwc_pkg::POS_W'(40)) begin
        boot[{2'b11, byte_position[2:0]}] <= byte_value;
      end
      if (byte_position >= fpwc_pkg::POS_W'(fpwc_pkg::ENTRY0_LBA) &&
          byte_position < fpwc_pkg::POS_W'(fpwc_pkg::ENTRY0_LBA + 8)) begin
        entry_lba[3'(byte_position - fpwc_pkg::POS_W'(fpwc_pkg::ENTRY0_LBA))] <= byte_value;
      end
      if (byte_position == fpwc_pkg::POS_W'(fpwc_pkg::ENTRY0_TYPE)) begin
        entry_type <= byte_value;
      end
      if (byte_position == fpwc_pkg::POS_W'(fpwc_pkg::SECTOR_BYTES - 2)) begin
        sig_low <= byte_value;
      end
    end
  end

  assign full_sector = byte_position == fpwc_pkg::POS_W'(fpwc_pkg::SECTOR_BYTES - 1);

  assign bytes_per_sector = {boot[12], boot[11]};
  assign reserved         = {boot[15], boot[14]};
  assign total16          = {boot[20], boot[19]};
  assign fat16_size       = {boot[23], boot[22]};
  assign total32          = {boot[27], boot[26], boot[25], boot[24]};
  assign fat32_size       = {boot[31], boot[30], boot[29], boot[28]};
  assign spc              = boot[13];
  assign nf               = boot[16];
  assign first = {entry_lba[3], entry_lba[2], entry_lba[1], entry_lba[0]};
  assign size  = {entry_lba[7], entry_lba[6], entry_lba[5], entry_lba[4]};
  assign room  = card_blocks - first;

  assign boot_ok = (boot[0] == fpwc_pkg::OP_JMP_SHORT && boot[2] == fpwc_pkg::OP_NOP) ||
                   boot[0] == fpwc_pkg::OP_JMP_NEAR;
  assign bpb_ok  = bytes_per_sector == 16'(fpwc_pkg::SECTOR_BYTES) &&
                   spc != 8'd0 && (spc & (spc - 8'd1)) == 8'd0 &&
                   reserved != 16'd0 && (nf == 8'd1 || nf == 8'd2) &&
                   !(fat16_size == 16'd0 && fat32_size == 32'd0) &&
                   !(total16 == 16'd0 && total32 == 32'd0);
  assign mbr_ok  = fpwc_pkg::fat_type(entry_type) && first != 32'd0 && size != 32'd0 &&
                   first < card_blocks && size <= room;

  always_comb begin
    result.layout = fpwc_pkg::LAYOUT_NONE;
    result.start  = '0;
    result.size   = '0;
    priority if (format_mode) begin
      result.size = card_blocks;
      if (card_blocks != 32'd0) begin
        result.layout = fpwc_pkg::LAYOUT_WHOLE;
      end
    end else if (!full_sector || card_blocks == 32'd0 ||
                 sig_low != fpwc_pkg::SIG_LOW || byte_value != fpwc_pkg::SIG_HIGH) begin
      result.layout = fpwc_pkg::LAYOUT_NONE;
    end else if (boot_ok && bpb_ok) begin
      result.layout = fpwc_pkg::LAYOUT_WHOLE;
      result.size   = card_blocks;
    end else if (mbr_ok) begin
      result.layout = fpwc_pkg::LAYOUT_MBR;
      result.start  = first;
      result.size   = size;
    end else begin
      result.layout = fpwc_pkg::LAYOUT_NONE;
    end
  end

endmodule

`default_nettype wire

### src/fat_partition_window_checker_top.sv
// an accepted item passes the input register and then the result register on its way to the master side
// throughput: one item per cycle while the master side does not stall, sector bytes and access checks alike
// an input register and a result register bound one pass of compare logic
// sector bytes other than the last give no result item
// rst clears the byte position, the window, the configuration and both valids
`default_nettype none

// ----------------------------------------------------------------------------
// fat_partition_window_checker_top
// fat layout detection from sector 0 and bounds check of accesses to the window
// ----------------------------------------------------------------------------
module fat_partition_window_checker_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [31:0]                       cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // byte_value, logical_sector, sector_count
  input  wire logic [fpwc_pkg::IN_DATA_W-1:0]    s_tdata,
  // command
  input  wire logic                              s_tuser,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // status, layout, window_start, window_blocks, physical_lba, zero fill
  output logic [fpwc_pkg::OUT_DATA_W-1:0]        m_tdata,
  // reply_kind
  output logic                                   m_tuser
);

  logic [31:0] card_blocks;
  logic        format_mode;

  logic        in_valid, in_cmd, in_last;
  logic [7:0]  in_byte;
  logic [31:0] in_logical, in_count;

  logic [31:0] partition_start, partition_size;

  logic        out_kind, out_status;
  logic [1:0]  out_layout;
  logic [31:0] out_start, out_size, out_lba;

  logic advance, work, det_en, det_done;
  fpwc_pkg::det_result_t det;
  logic        acc_ok;
  logic [31:0] acc_room;
  fpwc_pkg::layout_t acc_layout;

  // nothing is taken while in reset
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      card_blocks <= '0;
      format_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpwc_pkg::CFG_CARD_BLOCKS: card_blocks <= cfg_data;
        fpwc_pkg::CFG_FORMAT_MODE: format_mode <= cfg_data[0];
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !rst && (!in_valid || advance);
  assign work     = in_valid && advance;
  assign det_en   = work && in_cmd == fpwc_pkg::CMD_SECTOR_BYTE;
  assign det_done = det_en && in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd     <= s_tuser;
      in_last    <= s_tlast;
      in_byte    <= s_tdata[7:0];
      in_logical <= s_tdata[39:8];
      in_count   <= s_tdata[71:40];
    end
  end

  fpwc_detect u_detect (
    .clk         (clk),
    .rst         (rst),
    .en          (det_en),
    .byte_value  (in_byte),
    .last_byte   (in_last),
    .card_blocks (card_blocks),
    .format_mode (format_mode),
    .result      (det)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_start <= '0;
      partition_size  <= '0;
    end else if (det_done) begin
      partition_start <= det.start;
      partition_size  <= det.size;
    end
  end

  // overflow-safe window check
  assign acc_room = partition_size - in_logical;
  assign acc_ok   = in_count != 32'd0 && in_logical < partition_size &&
                    in_count <= acc_room && in_logical <= (fpwc_pkg::LBA_MAX - partition_start);

  always_comb begin
    if (partition_size == 32'd0) begin
      acc_layout = fpwc_pkg::LAYOUT_NONE;
    end else if (partition_start == 32'd0) begin
      acc_layout = fpwc_pkg::LAYOUT_WHOLE;
    end else begin
      acc_layout = fpwc_pkg::LAYOUT_MBR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && (in_cmd == fpwc_pkg::CMD_ACCESS || in_last);
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      if (in_cmd == fpwc_pkg::CMD_ACCESS) begin
        out_kind   <= fpwc_pkg::REPLY_ACCESS;
        out_status <= acc_ok ? fpwc_pkg::STATUS_OK : fpwc_pkg::STATUS_ERROR;
        out_layout <= acc_layout;
        out_start  <= partition_start;
        out_size   <= partition_size;
        out_lba    <= acc_ok ? partition_start + in_logical : 32'd0;
      end else begin
        out_kind   <= fpwc_pkg::REPLY_DETECT;
        out_status <= (det.layout == fpwc_pkg::LAYOUT_NONE) ? fpwc_pkg::STATUS_ERROR
                                                            : fpwc_pkg::STATUS_OK;
        out_layout <= det.layout;
        out_start  <= det.start;
        out_size   <= det.size;
        out_lba    <= 32'd0;
      end
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {5'd0, out_lba, out_size, out_start, out_layout, out_status};

endmodule

`default_nettype wire

### src/fpwc_checker.sv
// ----------------------------------------------------------------------------
// fpwc_checker
// port-level assertions for the fat partition window checker
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat_partition_window_checker_top_macros.svh"

module fpwc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [fpwc_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                           m_tuser
);

  // stalled result item holds
  `FPWC_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result item changed")

  // detection succeeds exactly when a layout was found
  `FPWC_ASSERT_IMPLY(a_det_status, clk, rst, m_tvalid && m_tuser == fpwc_pkg::REPLY_DETECT, (m_tdata[0] == fpwc_pkg::STATUS_OK) == (m_tdata[2:1] != 2'd0), "detection status and layout disagree")

  // no translated address in detection replies or rejected accesses
  `FPWC_ASSERT_IMPLY(a_lba_zero, clk, rst, m_tvalid && (m_tuser == fpwc_pkg::REPLY_DETECT || m_tdata[0] == fpwc_pkg::STATUS_ERROR), m_tdata[98:67] == 32'd0, "physical address set without accepted access")

  // an accepted access needs a nonempty window
  `FPWC_ASSERT_IMPLY(a_acc_window, clk, rst, m_tvalid && m_tuser == fpwc_pkg::REPLY_ACCESS && m_tdata[0] == fpwc_pkg::STATUS_OK, m_tdata[66:35] != 32'd0 && m_tdata[2:1] != 2'd0, "access accepted with empty window")

endmodule

bind fat_partition_window_checker_top fpwc_checker u_fpwc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
